FILE: design/istm_pkg.sv
// shared types and constants for the inverse spacetime metric unit
`timescale 1ns / 1ps

package istm_pkg;

    localparam logic [1:0] ST_OK         = 2'd0;
    localparam logic [1:0] ST_ZERO_LAPSE = 2'd1;
    localparam logic [1:0] ST_ZERO_DET   = 2'd2;
    localparam logic [1:0] ST_SAT        = 2'd3;

    localparam int QUEUE_DEPTH = 4;

    typedef struct packed {
        logic zero_lapse;
        logic zero_det;
        logic sat;
    } flags_t;

endpackage

FILE: design/istm_div.sv
// pipelined rounding fixed-point divider, one quotient bit per stage
`timescale 1ns / 1ps

module istm_div #(
    parameter int W = 32,
    parameter int F = 24
) (
    input  logic         clk,
    input  logic         enable,
    input  logic [W-1:0] num,
    input  logic [W-1:0] den,
    output logic [W-1:0] quo,
    output logic         ovf
);

    localparam int NW = W + F + 2;
    localparam logic [W-1:0] MAXV = {1'b0, {(W-1){1'b1}}};
    localparam logic [W-1:0] MINV = {1'b1, {(W-1){1'b0}}};

    logic [W-1:0]  mag_n;
    logic [W-1:0]  mag_d;
    logic [NW-1:0] nm;
    logic [W:0]    dn;
    logic          big;

    logic [W:0]   rem_reg [W+1];
    logic [W-1:0] low_reg [W+1];
    logic [W-1:0] q_reg   [W+1];
    logic [W:0]   den_reg [W+1];
    logic         neg_reg [W+1];
    logic         big_reg [W+1];

    logic [W-1:0] quo_reg;
    logic         ovf_reg;
    logic [W-1:0] quo_next;
    logic         ovf_next;

    // numerator carries a half divisor so the floor rounds to nearest
    always_comb
    begin
        mag_n = num[W-1] ? (~num + W'(1)) : num;
        mag_d = den[W-1] ? (~den + W'(1)) : den;
        nm    = NW'({mag_n, {(F+1){1'b0}}}) + NW'(mag_d);
        dn    = {mag_d, 1'b0};
        big   = NW'(nm[NW-1:W]) >= NW'(dn);
    end

    always_ff @(posedge clk)
    begin
        if (enable)
        begin
            rem_reg[0] <= (W+1)'(nm[NW-1:W]);
            low_reg[0] <= nm[W-1:0];
            q_reg[0]   <= '0;
            den_reg[0] <= dn;
            neg_reg[0] <= num[W-1] ^ den[W-1];
            big_reg[0] <= big;
        end
    end

    for (genvar i = 1; i <= W; i++)
    begin : g_step
        logic [W+1:0] r2;
        logic         take;

        always_comb
        begin
            r2   = {rem_reg[i-1], low_reg[i-1][W-1]};
            take = r2 >= {1'b0, den_reg[i-1]};
        end

        always_ff @(posedge clk)
        begin
            if (enable)
            begin
                rem_reg[i] <= take ? (W+1)'(r2 - {1'b0, den_reg[i-1]}) : r2[W:0];
                low_reg[i] <= {low_reg[i-1][W-2:0], 1'b0};
                q_reg[i]   <= {q_reg[i-1][W-2:0], take};
                den_reg[i] <= den_reg[i-1];
                neg_reg[i] <= neg_reg[i-1];
                big_reg[i] <= big_reg[i-1];
            end
        end
    end

    always_comb
    begin
        quo_next = q_reg[W];
        ovf_next = 1'b0;
        if (big_reg[W])
        begin
            ovf_next = 1'b1;
            quo_next = neg_reg[W] ? MINV : MAXV;
        end
        else if (neg_reg[W])
        begin
            if (q_reg[W] > MINV)
            begin
                ovf_next = 1'b1;
                quo_next = MINV;
            end
            else
            begin
                quo_next = ~q_reg[W] + W'(1);
            end
        end
        else if (q_reg[W][W-1])
        begin
            ovf_next = 1'b1;
            quo_next = MAXV;
        end
    end

    always_ff @(posedge clk)
    begin
        if (enable)
        begin
            quo_reg <= quo_next;
            ovf_reg <= ovf_next;
        end
    end

    assign quo = quo_reg;
    assign ovf = ovf_reg;

endmodule

FILE: design/istm_front.sv
// front pipeline: products, cofactors, determinant and classification
`timescale 1ns / 1ps

module istm_front #(
    parameter int W = 32,
    parameter int F = 24
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                enable,
    input  logic                in_fire,
    input  logic signed [W-1:0] lapse,
    input  logic signed [W-1:0] shift_x,
    input  logic signed [W-1:0] shift_y,
    input  logic signed [W-1:0] shift_z,
    input  logic signed [W-1:0] metric_xx,
    input  logic signed [W-1:0] metric_xy,
    input  logic signed [W-1:0] metric_xz,
    input  logic signed [W-1:0] metric_yy,
    input  logic signed [W-1:0] metric_yz,
    input  logic signed [W-1:0] metric_zz,
    output logic                out_valid,
    output logic [W-1:0]        a2,
    output logic [W-1:0]        det,
    output logic [6*W-1:0]      cof,
    output logic [6*W-1:0]      bbq,
    output logic [3*W-1:0]      shv,
    output istm_pkg::flags_t    flags
);

    localparam int NP = 19;
    localparam logic [2*W:0] RND = (2*W+1)'(1) << (F-1);
    localparam logic [W-1:0] MAXV = {1'b0, {(W-1){1'b1}}};
    localparam logic [W-1:0] MINV = {1'b1, {(W-1){1'b0}}};

    // rounded product, top bit is the overflow flag
    function automatic logic [W:0] round_sat(input logic [2*W-1:0] p);
        logic [2*W:0]   t;
        logic [2*W-F:0] s;
        logic           of;
        t  = {p[2*W-1], p} + RND;
        s  = t[2*W:F];
        of = s[2*W-F:W-1] != {(W-F+2){s[W-1]}};
        if (of)
            return {1'b1, (s[2*W-F] ? MINV : MAXV)};
        return {1'b0, s[W-1:0]};
    endfunction

    function automatic logic [W:0] diff_sat(input logic [W-1:0] a, input logic [W-1:0] b);
        logic [W:0] t;
        t = {a[W-1], a} - {b[W-1], b};
        if (t[W] != t[W-1])
            return {1'b1, (t[W] ? MINV : MAXV)};
        return {1'b0, t[W-1:0]};
    endfunction

    logic signed [W-1:0] opa [NP];
    logic signed [W-1:0] opb [NP];

    always_comb
    begin
        opa[0]  = lapse;     opb[0]  = lapse;
        opa[1]  = metric_yy; opb[1]  = metric_zz;
        opa[2]  = metric_yz; opb[2]  = metric_yz;
        opa[3]  = metric_xz; opb[3]  = metric_yz;
        opa[4]  = metric_xy; opb[4]  = metric_zz;
        opa[5]  = metric_xy; opb[5]  = metric_yz;
        opa[6]  = metric_xz; opb[6]  = metric_yy;
        opa[7]  = metric_xx; opb[7]  = metric_zz;
        opa[8]  = metric_xz; opb[8]  = metric_xz;
        opa[9]  = metric_xy; opb[9]  = metric_xz;
        opa[10] = metric_xx; opb[10] = metric_yz;
        opa[11] = metric_xx; opb[11] = metric_yy;
        opa[12] = metric_xy; opb[12] = metric_xy;
        opa[13] = shift_x;   opb[13] = shift_x;
        opa[14] = shift_x;   opb[14] = shift_y;
        opa[15] = shift_x;   opb[15] = shift_z;
        opa[16] = shift_y;   opb[16] = shift_y;
        opa[17] = shift_y;   opb[17] = shift_z;
        opa[18] = shift_z;   opb[18] = shift_z;
    end

    logic s1_v_reg, s2_v_reg, s3_v_reg, s4_v_reg, s5_v_reg, s6_v_reg;

    // stage 1: raw products
    logic signed [2*W-1:0] s1_prod_reg [NP];
    logic [W-1:0]          s1_sh_reg [3];
    logic [W-1:0]          s1_gx_reg [3];

    always_ff @(posedge clk)
    begin
        if (enable)
        begin
            for (int k = 0; k < NP; k++)
                s1_prod_reg[k] <= opa[k] * opb[k];
            s1_sh_reg[0] <= shift_x;
            s1_sh_reg[1] <= shift_y;
            s1_sh_reg[2] <= shift_z;
            s1_gx_reg[0] <= metric_xx;
            s1_gx_reg[1] <= metric_xy;
            s1_gx_reg[2] <= metric_xz;
        end
    end

    // stage 2: round and saturate
    logic [W:0]   rs [NP];
    logic         rs_sat;
    logic [W-1:0] s2_r_reg [NP];
    logic [W-1:0] s2_sh_reg [3];
    logic [W-1:0] s2_gx_reg [3];
    logic         s2_sat_reg;

    always_comb
    begin
        rs_sat = 1'b0;
        for (int k = 0; k < NP; k++)
        begin
            rs[k]  = round_sat(s1_prod_reg[k]);
            rs_sat = rs_sat | rs[k][W];
        end
    end

    always_ff @(posedge clk)
    begin
        if (enable)
        begin
            for (int k = 0; k < NP; k++)
                s2_r_reg[k] <= rs[k][W-1:0];
            s2_sh_reg  <= s1_sh_reg;
            s2_gx_reg  <= s1_gx_reg;
            s2_sat_reg <= rs_sat;
        end
    end

    // stage 3: cofactors
    logic [W:0]   cd [6];
    logic         cd_sat;
    logic [W-1:0] s3_c_reg [6];
    logic [W-1:0] s3_bb_reg [6];
    logic [W-1:0] s3_a2_reg;
    logic [W-1:0] s3_sh_reg [3];
    logic [W-1:0] s3_gx_reg [3];
    logic         s3_sat_reg;

    always_comb
    begin
        cd_sat = 1'b0;
        for (int k = 0; k < 6; k++)
        begin
            cd[k]  = diff_sat(s2_r_reg[1+2*k], s2_r_reg[2+2*k]);
            cd_sat = cd_sat | cd[k][W];
        end
    end

    always_ff @(posedge clk)
    begin
        if (enable)
        begin
            for (int k = 0; k < 6; k++)
            begin
                s3_c_reg[k]  <= cd[k][W-1:0];
                s3_bb_reg[k] <= s2_r_reg[13+k];
            end
            s3_a2_reg  <= s2_r_reg[0];
            s3_sh_reg  <= s2_sh_reg;
            s3_gx_reg  <= s2_gx_reg;
            s3_sat_reg <= s2_sat_reg | cd_sat;
        end
    end

    // stage 4: determinant products along the first row
    logic signed [2*W-1:0] s4_dp_reg [3];
    logic [W-1:0]          s4_c_reg [6];
    logic [W-1:0]          s4_bb_reg [6];
    logic [W-1:0]          s4_a2_reg;
    logic [W-1:0]          s4_sh_reg [3];
    logic                  s4_sat_reg;

    always_ff @(posedge clk)
    begin
        if (enable)
        begin
            for (int k = 0; k < 3; k++)
                s4_dp_reg[k] <= $signed(s3_gx_reg[k]) * $signed(s3_c_reg[k]);
            s4_c_reg   <= s3_c_reg;
            s4_bb_reg  <= s3_bb_reg;
            s4_a2_reg  <= s3_a2_reg;
            s4_sh_reg  <= s3_sh_reg;
            s4_sat_reg <= s3_sat_reg;
        end
    end

    // stage 5: round determinant terms
    logic [W:0]   dr [3];
    logic [W-1:0] s5_dr_reg [3];
    logic [W-1:0] s5_c_reg [6];
    logic [W-1:0] s5_bb_reg [6];
    logic [W-1:0] s5_a2_reg;
    logic [W-1:0] s5_sh_reg [3];
    logic         s5_sat_reg;

    always_comb
    begin
        for (int k = 0; k < 3; k++)
            dr[k] = round_sat(s4_dp_reg[k]);
    end

    always_ff @(posedge clk)
    begin
        if (enable)
        begin
            for (int k = 0; k < 3; k++)
                s5_dr_reg[k] <= dr[k][W-1:0];
            s5_c_reg   <= s4_c_reg;
            s5_bb_reg  <= s4_bb_reg;
            s5_a2_reg  <= s4_a2_reg;
            s5_sh_reg  <= s4_sh_reg;
            s5_sat_reg <= s4_sat_reg | dr[0][W] | dr[1][W] | dr[2][W];
        end
    end

    // stage 6: exact three-term sum, saturate, classify
    logic [W+1:0]     dsum;
    logic             dsum_of;
    logic [W-1:0]     det_val;
    logic [W-1:0]     s6_det_reg;
    logic [W-1:0]     s6_c_reg [6];
    logic [W-1:0]     s6_bb_reg [6];
    logic [W-1:0]     s6_a2_reg;
    logic [W-1:0]     s6_sh_reg [3];
    istm_pkg::flags_t s6_flags_reg;

    always_comb
    begin
        dsum = {{2{s5_dr_reg[0][W-1]}}, s5_dr_reg[0]}
             + {{2{s5_dr_reg[1][W-1]}}, s5_dr_reg[1]}
             + {{2{s5_dr_reg[2][W-1]}}, s5_dr_reg[2]};
        dsum_of = dsum[W+1:W-1] != {3{dsum[W-1]}};
        if (dsum_of)
            det_val = dsum[W+1] ? MINV : MAXV;
        else
            det_val = dsum[W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (enable)
        begin
            s6_det_reg              <= det_val;
            s6_c_reg                <= s5_c_reg;
            s6_bb_reg               <= s5_bb_reg;
            s6_a2_reg               <= s5_a2_reg;
            s6_sh_reg               <= s5_sh_reg;
            s6_flags_reg.zero_lapse <= s5_a2_reg == '0;
            s6_flags_reg.zero_det   <= det_val == '0;
            s6_flags_reg.sat        <= s5_sat_reg | dsum_of;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg <= 1'b0;
            s2_v_reg <= 1'b0;
            s3_v_reg <= 1'b0;
            s4_v_reg <= 1'b0;
            s5_v_reg <= 1'b0;
            s6_v_reg <= 1'b0;
        end
        else if (enable)
        begin
            s1_v_reg <= in_fire;
            s2_v_reg <= s1_v_reg;
            s3_v_reg <= s2_v_reg;
            s4_v_reg <= s3_v_reg;
            s5_v_reg <= s4_v_reg;
            s6_v_reg <= s5_v_reg;
        end
    end

    assign out_valid = s6_v_reg;
    assign a2        = s6_a2_reg;
    assign det       = s6_det_reg;
    assign flags     = s6_flags_reg;

    for (genvar k = 0; k < 6; k++)
    begin : g_pack6
        assign cof[k*W +: W] = s6_c_reg[k];
        assign bbq[k*W +: W] = s6_bb_reg[k];
    end

    for (genvar k = 0; k < 3; k++)
    begin : g_pack3
        assign shv[k*W +: W] = s6_sh_reg[k];
    end

endmodule

FILE: design/istm_queue.sv
// short request queue between the front and back pipelines
`timescale 1ns / 1ps

module istm_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] din,
    input  logic             pop,
    output logic [WIDTH-1:0] dout,
    output logic             full,
    output logic             empty
);

    localparam int AW = $clog2(DEPTH);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [AW-1:0]    wr_ptr_reg;
    logic [AW-1:0]    rd_ptr_reg;
    logic [AW:0]      count_reg;
    logic [AW-1:0]    wr_ptr_next;
    logic [AW-1:0]    rd_ptr_next;

    always_comb
    begin
        wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + AW'(1);
        rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + AW'(1);
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= din;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_next;
            if (pop)
                rd_ptr_reg <= rd_ptr_next;
            if (push && !pop)
                count_reg <= count_reg + (AW+1)'(1);
            else if (pop && !push)
                count_reg <= count_reg - (AW+1)'(1);
        end
    end

    assign dout  = mem[rd_ptr_reg];
    assign full  = count_reg == (AW+1)'(DEPTH);
    assign empty = count_reg == '0;

endmodule

FILE: design/istm_back.sv
// back pipeline: sixteen pipelined divisions, final differences and status
`timescale 1ns / 1ps

module istm_back #(
    parameter int W = 32,
    parameter int F = 24
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_pop,
    input  logic [W-1:0]     a2,
    input  logic [W-1:0]     det,
    input  logic [6*W-1:0]   cof,
    input  logic [6*W-1:0]   bbq,
    input  logic [3*W-1:0]   shv,
    input  istm_pkg::flags_t flags,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [W-1:0]     inv_tt,
    output logic [W-1:0]     inv_tx,
    output logic [W-1:0]     inv_ty,
    output logic [W-1:0]     inv_tz,
    output logic [W-1:0]     inv_xx,
    output logic [W-1:0]     inv_xy,
    output logic [W-1:0]     inv_xz,
    output logic [W-1:0]     inv_yy,
    output logic [W-1:0]     inv_yz,
    output logic [W-1:0]     inv_zz,
    output logic [W-1:0]     spatial_determinant,
    output logic [1:0]       status
);

    localparam int LAT = W + 2;
    localparam int ND  = 16;
    localparam logic [W-1:0] NEG_UNIT = ~(W'(1) << F) + W'(1);
    localparam logic [W-1:0] MAXV = {1'b0, {(W-1){1'b1}}};
    localparam logic [W-1:0] MINV = {1'b1, {(W-1){1'b0}}};

    function automatic logic [W:0] diff_sat(input logic [W-1:0] a, input logic [W-1:0] b);
        logic [W:0] t;
        t = {a[W-1], a} - {b[W-1], b};
        if (t[W] != t[W-1])
            return {1'b1, (t[W] ? MINV : MAXV)};
        return {1'b0, t[W-1:0]};
    endfunction

    logic advance;
    logic out_valid_reg;

    assign advance = !out_valid_reg || out_ready;
    assign in_pop  = advance && in_valid;

    // divisions: tt, three ti, six spatial inverse terms, six shift terms
    logic [W-1:0] dnum [ND];
    logic [W-1:0] dden [ND];
    logic [W-1:0] dq   [ND];
    logic         dovf [ND];

    always_comb
    begin
        dnum[0] = NEG_UNIT;
        dden[0] = a2;
        for (int k = 0; k < 3; k++)
        begin
            dnum[1+k] = shv[k*W +: W];
            dden[1+k] = a2;
        end
        for (int k = 0; k < 6; k++)
        begin
            dnum[4+k]  = cof[k*W +: W];
            dden[4+k]  = det;
            dnum[10+k] = bbq[k*W +: W];
            dden[10+k] = a2;
        end
    end

    for (genvar g = 0; g < ND; g++)
    begin : g_div
        istm_div #(
            .W(W),
            .F(F)
        ) u_div (
            .clk    (clk),
            .enable (advance),
            .num    (dnum[g]),
            .den    (dden[g]),
            .quo    (dq[g]),
            .ovf    (dovf[g])
        );
    end

    // side line matched to divider latency
    logic             v_reg   [LAT];
    logic [W-1:0]     det_reg [LAT];
    istm_pkg::flags_t fl_reg  [LAT];

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            det_reg[0] <= det;
            fl_reg[0]  <= flags;
            for (int i = 1; i < LAT; i++)
            begin
                det_reg[i] <= det_reg[i-1];
                fl_reg[i]  <= fl_reg[i-1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < LAT; i++)
                v_reg[i] <= 1'b0;
        end
        else if (advance)
        begin
            v_reg[0] <= in_pop;
            for (int i = 1; i < LAT; i++)
                v_reg[i] <= v_reg[i-1];
        end
    end

    // final differences and status priority
    logic [W:0]       ij [6];
    logic             sat_all;
    istm_pkg::flags_t fl;
    logic [W-1:0]     inv_next [10];
    logic [1:0]       status_next;

    always_comb
    begin
        fl      = fl_reg[LAT-1];
        sat_all = fl.sat;
        for (int k = 0; k < ND; k++)
            sat_all = sat_all | dovf[k];
        for (int k = 0; k < 6; k++)
        begin
            ij[k]   = diff_sat(dq[4+k], dq[10+k]);
            sat_all = sat_all | ij[k][W];
        end
        for (int k = 0; k < 10; k++)
            inv_next[k] = '0;
        if (fl.zero_lapse)
        begin
            status_next = istm_pkg::ST_ZERO_LAPSE;
        end
        else
        begin
            for (int k = 0; k < 4; k++)
                inv_next[k] = dq[k];
            if (fl.zero_det)
            begin
                status_next = istm_pkg::ST_ZERO_DET;
            end
            else
            begin
                for (int k = 0; k < 6; k++)
                    inv_next[4+k] = ij[k][W-1:0];
                status_next = sat_all ? istm_pkg::ST_SAT : istm_pkg::ST_OK;
            end
        end
    end

    logic [W-1:0] inv_reg [10];
    logic [W-1:0] sdet_reg;
    logic [1:0]   status_reg;

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            inv_reg    <= inv_next;
            sdet_reg   <= det_reg[LAT-1];
            status_reg <= status_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= v_reg[LAT-1];
    end

    assign out_valid           = out_valid_reg;
    assign inv_tt              = inv_reg[0];
    assign inv_tx              = inv_reg[1];
    assign inv_ty              = inv_reg[2];
    assign inv_tz              = inv_reg[3];
    assign inv_xx              = inv_reg[4];
    assign inv_xy              = inv_reg[5];
    assign inv_xz              = inv_reg[6];
    assign inv_yy              = inv_reg[7];
    assign inv_yz              = inv_reg[8];
    assign inv_zz              = inv_reg[9];
    assign spatial_determinant = sdet_reg;
    assign status              = status_reg;

endmodule

FILE: design/inverse_spacetime_metric_unit.sv
// top level of the inverse spacetime metric unit
// Takes one grid point per request on the input channel (in_valid/in_ready):
// lapse, shift and the six spatial metric components, signed fixed point.
// Returns one result per request on the output channel (out_valid/out_ready):
// the ten inverse 4-metric components, the spatial determinant and a status.
// Throughput is one point per cycle while the queue has room (in_ready high).
// A point passes through six front stages for products, cofactors and
// determinant, the four-entry queue, then the bit-per-stage dividers
// and one output register.
// The divider pipeline length, one quotient bit per stage, sets the latency.
// When out_ready is low the back pipeline holds; the queue keeps absorbing
// front results until it fills, then in_ready drops and the front holds.
// Reset clears all valid bits and the queue; no result is pending after it.
`timescale 1ns / 1ps

module inverse_spacetime_metric_unit #(
    parameter int DATA_WIDTH = 32,
    parameter int FRAC_BITS  = 24
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [DATA_WIDTH-1:0] lapse,
    input  logic [DATA_WIDTH-1:0] shift_x,
    input  logic [DATA_WIDTH-1:0] shift_y,
    input  logic [DATA_WIDTH-1:0] shift_z,
    input  logic [DATA_WIDTH-1:0] metric_xx,
    input  logic [DATA_WIDTH-1:0] metric_xy,
    input  logic [DATA_WIDTH-1:0] metric_xz,
    input  logic [DATA_WIDTH-1:0] metric_yy,
    input  logic [DATA_WIDTH-1:0] metric_yz,
    input  logic [DATA_WIDTH-1:0] metric_zz,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [DATA_WIDTH-1:0] inv_tt,
    output logic [DATA_WIDTH-1:0] inv_tx,
    output logic [DATA_WIDTH-1:0] inv_ty,
    output logic [DATA_WIDTH-1:0] inv_tz,
    output logic [DATA_WIDTH-1:0] inv_xx,
    output logic [DATA_WIDTH-1:0] inv_xy,
    output logic [DATA_WIDTH-1:0] inv_xz,
    output logic [DATA_WIDTH-1:0] inv_yy,
    output logic [DATA_WIDTH-1:0] inv_yz,
    output logic [DATA_WIDTH-1:0] inv_zz,
    output logic [DATA_WIDTH-1:0] spatial_determinant,
    output logic [1:0]            status
);

    localparam int W  = DATA_WIDTH;
    localparam int QW = $bits(istm_pkg::flags_t) + 17 * W;

    logic             q_full;
    logic             q_empty;
    logic             q_pop;
    logic [QW-1:0]    q_din;
    logic [QW-1:0]    q_dout;

    logic             f_valid;
    logic [W-1:0]     f_a2;
    logic [W-1:0]     f_det;
    logic [6*W-1:0]   f_cof;
    logic [6*W-1:0]   f_bbq;
    logic [3*W-1:0]   f_shv;
    istm_pkg::flags_t f_flags;

    logic [W-1:0]     b_a2;
    logic [W-1:0]     b_det;
    logic [6*W-1:0]   b_cof;
    logic [6*W-1:0]   b_bbq;
    logic [3*W-1:0]   b_shv;
    istm_pkg::flags_t b_flags;

    assign in_ready = !q_full;

    istm_front #(
        .W(W),
        .F(FRAC_BITS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .enable    (!q_full),
        .in_fire   (in_valid && in_ready),
        .lapse     (lapse),
        .shift_x   (shift_x),
        .shift_y   (shift_y),
        .shift_z   (shift_z),
        .metric_xx (metric_xx),
        .metric_xy (metric_xy),
        .metric_xz (metric_xz),
        .metric_yy (metric_yy),
        .metric_yz (metric_yz),
        .metric_zz (metric_zz),
        .out_valid (f_valid),
        .a2        (f_a2),
        .det       (f_det),
        .cof       (f_cof),
        .bbq       (f_bbq),
        .shv       (f_shv),
        .flags     (f_flags)
    );

    assign q_din = {f_flags, f_a2, f_det, f_cof, f_bbq, f_shv};

    istm_queue #(
        .WIDTH(QW),
        .DEPTH(istm_pkg::QUEUE_DEPTH)
    ) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (f_valid && !q_full),
        .din   (q_din),
        .pop   (q_pop),
        .dout  (q_dout),
        .full  (q_full),
        .empty (q_empty)
    );

    assign {b_flags, b_a2, b_det, b_cof, b_bbq, b_shv} = q_dout;

    istm_back #(
        .W(W),
        .F(FRAC_BITS)
    ) u_back (
        .clk                 (clk),
        .rst_n               (rst_n),
        .in_valid            (!q_empty),
        .in_pop              (q_pop),
        .a2                  (b_a2),
        .det                 (b_det),
        .cof                 (b_cof),
        .bbq                 (b_bbq),
        .shv                 (b_shv),
        .flags               (b_flags),
        .out_valid           (out_valid),
        .out_ready           (out_ready),
        .inv_tt              (inv_tt),
        .inv_tx              (inv_tx),
        .inv_ty              (inv_ty),
        .inv_tz              (inv_tz),
        .inv_xx              (inv_xx),
        .inv_xy              (inv_xy),
        .inv_xz              (inv_xz),
        .inv_yy              (inv_yy),
        .inv_yz              (inv_yz),
        .inv_zz              (inv_zz),
        .spatial_determinant (spatial_determinant),
        .status              (status)
    );

    a_queue_sane: assert property (@(posedge clk) disable iff (!rst_n)
        !(q_full && q_empty))
        else $error("queue reports full and empty at once");

    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> !q_empty)
        else $error("queue popped while empty");

    a_zero_lapse: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status == istm_pkg::ST_ZERO_LAPSE) |->
        (inv_tt == '0 && inv_tx == '0 && inv_xx == '0 && inv_zz == '0))
        else $error("zero lapse result carries nonzero components");

    a_zero_det: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status == istm_pkg::ST_ZERO_DET) |->
        (spatial_determinant == '0 && inv_xx == '0 && inv_yz == '0))
        else $error("zero determinant result inconsistent");

endmodule

FILE: tb/sv/inverse_spacetime_metric_unit_tb.sv
// testbench for the inverse spacetime metric unit: directed and random points vs a predictor
`timescale 1ns / 1ps

module inverse_spacetime_metric_unit_tb;

    localparam int          NUM_RANDOM = 1700;
    localparam int          DRAIN_CYCLES = 80;
    localparam logic [31:0] ONE = 32'h0100_0000;
    localparam logic [31:0] NEG_ONE = 32'hFF00_0000;
    localparam logic [31:0] MAX_V = 32'h7FFF_FFFF;
    localparam logic [31:0] MIN_V = 32'h8000_0000;

    typedef logic signed [127:0] wide_t;

    typedef struct {
        logic [31:0] f [10];
    } point_t;

    typedef struct {
        logic [31:0] v [11];
        logic [1:0]  st;
    } metric_out_t;

    typedef struct {
        point_t      pt;
        bit          typed;
        metric_out_t want;
    } row_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [31:0] lapse, shift_x, shift_y, shift_z;
    logic [31:0] metric_xx, metric_xy, metric_xz, metric_yy, metric_yz, metric_zz;
    logic        out_valid;
    logic        out_ready;
    logic [31:0] inv_tt, inv_tx, inv_ty, inv_tz, inv_xx, inv_xy, inv_xz;
    logic [31:0] inv_yy, inv_yz, inv_zz, spatial_determinant;
    logic [1:0]  status;

    metric_out_t pending_q[$];
    int          err_count;
    bit          clamped;
    string       field_names [11] = '{"inv_tt", "inv_tx", "inv_ty", "inv_tz", "inv_xx",
        "inv_xy", "inv_xz", "inv_yy", "inv_yz", "inv_zz", "spatial_determinant"};

    inverse_spacetime_metric_unit DUT (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
        .lapse(lapse), .shift_x(shift_x), .shift_y(shift_y), .shift_z(shift_z),
        .metric_xx(metric_xx), .metric_xy(metric_xy), .metric_xz(metric_xz),
        .metric_yy(metric_yy), .metric_yz(metric_yz), .metric_zz(metric_zz),
        .out_valid(out_valid), .out_ready(out_ready),
        .inv_tt(inv_tt), .inv_tx(inv_tx), .inv_ty(inv_ty), .inv_tz(inv_tz),
        .inv_xx(inv_xx), .inv_xy(inv_xy), .inv_xz(inv_xz), .inv_yy(inv_yy),
        .inv_yz(inv_yz), .inv_zz(inv_zz), .spatial_determinant(spatial_determinant),
        .status(status)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // fixed-point arithmetic at Q8.24, clamping sets the saturation mark
    function automatic longint clamp32(wide_t x);
        if (x > wide_t'(64'sd2147483647))
        begin
            clamped = 1'b1;
            return 64'sd2147483647;
        end
        if (x < -wide_t'(64'sd2147483648))
        begin
            clamped = 1'b1;
            return -64'sd2147483648;
        end
        return longint'(x[63:0]);
    endfunction

    function automatic longint fx_mul(longint a, longint b);
        wide_t p;
        p = wide_t'(a) * wide_t'(b) + (wide_t'(1) <<< 23);
        return clamp32(p >>> 24);
    endfunction

    function automatic longint fx_sub(longint a, longint b);
        return clamp32(wide_t'(a) - wide_t'(b));
    endfunction

    // round to nearest, ties away from zero
    function automatic longint fx_div(longint n, longint d);
        wide_t un, ud, q;
        un = (n < 0) ? -wide_t'(n) : wide_t'(n);
        ud = (d < 0) ? -wide_t'(d) : wide_t'(d);
        q = ((un <<< 25) + ud) / (ud <<< 1);
        if ((n < 0) != (d < 0))
            q = -q;
        return clamp32(q);
    endfunction

    function automatic metric_out_t predict_inverse(point_t p);
        metric_out_t r;
        longint      x [10];
        longint      cof [6];
        longint      a2, det;
        int          k;
        for (int i = 0; i < 10; i++)
            x[i] = longint'(signed'(p.f[i]));
        clamped = 1'b0;
        a2 = fx_mul(x[0], x[0]);
        cof[0] = fx_sub(fx_mul(x[7], x[9]), fx_mul(x[8], x[8]));
        cof[1] = fx_sub(fx_mul(x[6], x[8]), fx_mul(x[5], x[9]));
        cof[2] = fx_sub(fx_mul(x[5], x[8]), fx_mul(x[6], x[7]));
        cof[3] = fx_sub(fx_mul(x[4], x[9]), fx_mul(x[6], x[6]));
        cof[4] = fx_sub(fx_mul(x[5], x[6]), fx_mul(x[4], x[8]));
        cof[5] = fx_sub(fx_mul(x[4], x[7]), fx_mul(x[5], x[5]));
        det = clamp32(wide_t'(fx_mul(x[4], cof[0])) + wide_t'(fx_mul(x[5], cof[1]))
                      + wide_t'(fx_mul(x[6], cof[2])));
        for (int i = 0; i < 11; i++)
            r.v[i] = '0;
        r.v[10] = det[31:0];
        if (a2 == 0)
            r.st = istm_pkg::ST_ZERO_LAPSE;
        else
        begin
            r.v[0] = 32'(fx_div(-64'sd16777216, a2));
            for (int i = 0; i < 3; i++)
                r.v[1 + i] = 32'(fx_div(x[1 + i], a2));
            if (det == 0)
                r.st = istm_pkg::ST_ZERO_DET;
            else
            begin
                k = 0;
                for (int i = 0; i < 3; i++)
                    for (int j = i; j < 3; j++)
                    begin
                        r.v[4 + k] = 32'(fx_sub(fx_div(cof[k], det),
                                                fx_div(fx_mul(x[1 + i], x[1 + j]), a2)));
                        k++;
                    end
                r.st = clamped ? istm_pkg::ST_SAT : istm_pkg::ST_OK;
            end
        end
        return r;
    endfunction

    function automatic point_t mk_point(logic [31:0] a, sx, sy, sz, xx, xy, xz, yy, yz, zz);
        point_t p;
        p.f = '{a, sx, sy, sz, xx, xy, xz, yy, yz, zz};
        return p;
    endfunction

    function automatic metric_out_t mk_out(logic [31:0] tt, xx, yy, zz, det, logic [1:0] st);
        metric_out_t r;
        r.v = '{tt, 0, 0, 0, xx, 0, 0, yy, 0, zz, det};
        r.st = st;
        return r;
    endfunction

    function automatic logic [31:0] near_val(int unsigned span);
        return $urandom_range(0, 2 * span) - span;
    endfunction

    function automatic point_t random_point();
        point_t      p;
        int unsigned mode;
        mode = $urandom_range(0, 9);
        if (mode < 6)
        begin
            // physical-looking point: lapse near one, metric near identity
            p.f[0] = 32'h0040_0000 + $urandom_range(0, 32'h0180_0000);
            if ($urandom_range(0, 7) == 0)
                p.f[0] = -p.f[0];
            for (int i = 1; i < 4; i++)
                p.f[i] = near_val(32'h0080_0000);
            p.f[4] = ONE + near_val(32'h0060_0000);
            p.f[7] = ONE + near_val(32'h0060_0000);
            p.f[9] = ONE + near_val(32'h0060_0000);
            p.f[5] = near_val(32'h0030_0000);
            p.f[6] = near_val(32'h0030_0000);
            p.f[8] = near_val(32'h0030_0000);
        end
        else if (mode < 8)
        begin
            for (int i = 0; i < 10; i++)
                p.f[i] = $urandom();
        end
        else
        begin
            // tiny or huge magnitudes: zero lapse, degenerate metric, clamping
            for (int i = 0; i < 10; i++)
                p.f[i] = near_val(32'h0000_1000 << (4 * $urandom_range(0, 4)));
            if ($urandom_range(0, 1))
                p.f[0] = near_val(32'h1800);
        end
        return p;
    endfunction

    task automatic send_point(point_t p, bit typed, metric_out_t want);
        int unsigned gap;
        @(negedge clk);
        in_valid = 1'b1;
        {lapse, shift_x, shift_y, shift_z} = {p.f[0], p.f[1], p.f[2], p.f[3]};
        {metric_xx, metric_xy, metric_xz} = {p.f[4], p.f[5], p.f[6]};
        {metric_yy, metric_yz, metric_zz} = {p.f[7], p.f[8], p.f[9]};
        do
            @(posedge clk);
        while (!in_ready);
        pending_q.push_back(typed ? want : predict_inverse(p));
        gap = $urandom_range(0, 99);
        gap = (gap < 60) ? 0 : (gap < 92) ? $urandom_range(1, 3) : $urandom_range(8, 40);
        if (gap > 0)
        begin
            @(negedge clk);
            in_valid = 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
    endtask

    // sink side stalls
    initial
    begin
        int unsigned hold;
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            out_ready = 1'b1;
            repeat ($urandom_range(0, 20)) @(negedge clk);
            hold = $urandom_range(0, 99);
            hold = (hold < 70) ? $urandom_range(1, 3) : (hold < 85) ? 0 : $urandom_range(10, 60);
            if (hold > 0)
            begin
                out_ready = 1'b0;
                repeat (hold - 1) @(negedge clk);
            end
        end
    end

    always @(posedge clk)
    begin
        metric_out_t want;
        logic [31:0] got [11];
        if (rst_n && out_valid && out_ready)
        begin
            got = '{inv_tt, inv_tx, inv_ty, inv_tz, inv_xx, inv_xy, inv_xz, inv_yy, inv_yz,
                    inv_zz, spatial_determinant};
            if (pending_q.size() == 0)
            begin
                $error("result with no request outstanding");
                err_count++;
            end
            else
            begin
                want = pending_q.pop_front();
                for (int i = 0; i < 11; i++)
                    if (got[i] !== want.v[i])
                    begin
                        $error("%s expected %h actual %h", field_names[i], want.v[i], got[i]);
                        err_count++;
                    end
                if (status !== want.st)
                begin
                    $error("status expected %0d actual %0d", want.st, status);
                    err_count++;
                end
            end
        end
    end

    initial
    begin
        #10ms;
        $display("CHECKS FAILED");
        $finish;
    end

    initial
    begin
        row_t        rows[$];
        metric_out_t none;
        none = mk_out(0, 0, 0, 0, 0, istm_pkg::ST_OK);
        err_count = 0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        {lapse, shift_x, shift_y, shift_z} = '0;
        {metric_xx, metric_xy, metric_xz, metric_yy, metric_yz, metric_zz} = '0;

        // unit lapse, flat metric
        rows.push_back('{mk_point(ONE, 0, 0, 0, ONE, 0, 0, ONE, 0, ONE), 1'b1,
                         mk_out(NEG_ONE, ONE, ONE, ONE, ONE, istm_pkg::ST_OK)});
        // zero lapse keeps determinant only
        rows.push_back('{mk_point(0, 0, 0, 0, ONE, 0, 0, ONE, 0, ONE), 1'b1,
                         mk_out(0, 0, 0, 0, ONE, istm_pkg::ST_ZERO_LAPSE)});
        // singular spatial metric
        rows.push_back('{mk_point(ONE, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1'b1,
                         mk_out(NEG_ONE, 0, 0, 0, 0, istm_pkg::ST_ZERO_DET)});
        // lapse squared rounds to zero
        rows.push_back('{mk_point(32'h0000_0b00, ONE, ONE, ONE, ONE, 0, 0, ONE, 0, ONE), 0, none});
        rows.push_back('{mk_point(32'h0000_1000, ONE, 0, 0, ONE, 0, 0, ONE, 0, ONE), 0, none});
        rows.push_back('{mk_point(NEG_ONE, ONE, NEG_ONE, 32'h0080_0000,
                                  ONE, 32'h0010_0000, 0, ONE, 32'h0020_0000, ONE), 0, none});
        rows.push_back('{mk_point(MAX_V, MAX_V, MIN_V, MAX_V, ONE, 0, 0, ONE, 0, ONE), 0, none});
        rows.push_back('{mk_point(MIN_V, MIN_V, MAX_V, MIN_V, ONE, 0, 0, ONE, 0, ONE), 0, none});
        rows.push_back('{mk_point(ONE, MAX_V, MAX_V, MAX_V,
                                  MAX_V, MAX_V, MAX_V, MAX_V, MAX_V, MAX_V), 0, none});
        rows.push_back('{mk_point(ONE, MIN_V, MIN_V, MIN_V,
                                  MIN_V, MIN_V, MIN_V, MIN_V, MIN_V, MIN_V), 0, none});
        rows.push_back('{mk_point(ONE, 0, 0, 0, MAX_V, MIN_V, MAX_V, MIN_V, MAX_V, MIN_V), 0, none});
        rows.push_back('{mk_point(32'h0000_2000, ONE, 0, 0, ONE, 0, 0, ONE, 0, ONE), 0, none});
        rows.push_back('{mk_point(ONE, 0, 0, 0, 32'h0000_0100, 0, 0, 32'h0000_0100, 0,
                                  32'h0000_0100), 0, none});
        rows.push_back('{mk_point(ONE, ONE, ONE, ONE, ONE, ONE, ONE, ONE, ONE, ONE), 0, none});
        rows.push_back('{mk_point(32'hFFFF_FFFF, 1, 32'hFFFF_FFFF, 0, NEG_ONE, 0, 0, NEG_ONE, 0,
                                  NEG_ONE), 0, none});
        rows.push_back('{mk_point(32'h0200_0000, 32'h0300_0000, 0, 32'hFD00_0000,
                                  32'h0200_0000, 32'h0100_0000, 0, 32'h0200_0000, 0,
                                  32'h0200_0000), 0, none});

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (rows[i])
            send_point(rows[i].pt, rows[i].typed, rows[i].want);
        for (int n = 0; n < NUM_RANDOM; n++)
        begin
            if (n == NUM_RANDOM / 2)
            begin
                // let the pipeline run dry once
                @(negedge clk);
                in_valid = 1'b0;
                wait (pending_q.size() == 0);
            end
            send_point(random_point(), 1'b0, none);
        end
        @(negedge clk);
        in_valid = 1'b0;
        wait (pending_q.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (err_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
